### rtl/mjt_pkg.sv
// Shared widths, register codes and the configuration bundle of the min-jerk trajectory block.
`timescale 1ns / 1ps
`default_nettype none

package mjt_pkg;

	// Field widths
	localparam int unsigned TIME_W = 32;
	localparam int unsigned DUR_W  = 24;
	localparam int unsigned POS_W  = 16;
	localparam int unsigned ANAT_W = 17;
	localparam int unsigned IDX_W  = 2;
	localparam int unsigned DATA_W = 24;

	// Default phase resolution
	localparam int unsigned FRAC_BITS_DEFAULT = 16;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_EXTENDED     = 2'd0;
	localparam logic [IDX_W-1:0] REG_FLEXED       = 2'd1;
	localparam logic [IDX_W-1:0] REG_FLEX_DUR     = 2'd2;
	localparam logic [IDX_W-1:0] REG_EXT_DUR      = 2'd3;

	// Move directions
	localparam logic OP_FLEXION   = 1'b0;
	localparam logic OP_EXTENSION = 1'b1;

	// Reset values
	localparam logic [DUR_W-1:0] DUR_RESET = 24'd1000000;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic signed [POS_W-1:0] extended_position;
		logic signed [POS_W-1:0] flexed_position;
		logic [DUR_W-1:0]        flexion_duration;
		logic [DUR_W-1:0]        extension_duration;
	} cfg_t;

endpackage

`default_nettype wire

### rtl/mjt_phase.sv
// Elapsed time and phase: modular subtract, clamp test and a restoring divider, one bit a stage.
`timescale 1ns / 1ps
`default_nettype none

module mjt_phase #(
	parameter int unsigned FRACTION_BITS = mjt_pkg::FRAC_BITS_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                opcode,
	input  wire  [mjt_pkg::TIME_W-1:0]         start_time,
	input  wire  [mjt_pkg::TIME_W-1:0]         now_time,
	input  wire  mjt_pkg::cfg_t                cfg,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               out_op,
	output logic [FRACTION_BITS:0]             out_phase
);
	import mjt_pkg::*;

	localparam int unsigned F = FRACTION_BITS;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	// Stage 1: elapsed time and duration for the direction
	logic              v_s1;
	logic [TIME_W-1:0] el_s1;
	logic [DUR_W-1:0]  dur_s1;
	logic              op_s1;
	logic              rdy_s1;

	// Divider chain: index 0 is the clamp stage, 1..F produce one quotient bit each
	logic             dv_s   [0:F];
	logic [DUR_W-1:0] drem_s [0:F];
	logic [DUR_W-1:0] ddur_s [0:F];
	logic [F-1:0]     dq_s   [0:F];
	logic             dsat_s [0:F];
	logic             dop_s  [0:F];
	logic [F:0]       d_rdy;

	// Final stage: phase value
	logic       v_s3;
	logic [F:0] phase_s3;
	logic       op_s3;
	logic       rdy_s3;

	// Per-stage ready, bubbles collapse
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s1   = !v_s1 || d_rdy[0];
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			el_s1  <= now_time - start_time;
			dur_s1 <= (opcode == OP_EXTENSION) ? cfg.extension_duration : cfg.flexion_duration;
			op_s1  <= opcode;
		end
	end

	// Clamp stage: a move at or past its duration, or of no duration, is complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s[0] <= 1'b0;
		end else if (d_rdy[0]) begin
			dv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (d_rdy[0] && v_s1) begin
			dsat_s[0] <= (dur_s1 == '0) || (el_s1 >= TIME_W'(dur_s1));
			drem_s[0] <= el_s1[DUR_W-1:0];
			ddur_s[0] <= dur_s1;
			dq_s[0]   <= '0;
			dop_s[0]  <= op_s1;
		end
	end

	genvar j;
	generate
		for (j = 0; j <= F; j++) begin : g_rdy
			if (j == F) begin : g_last
				assign d_rdy[j] = !dv_s[j] || rdy_s3;
			end else begin : g_mid
				assign d_rdy[j] = !dv_s[j] || d_rdy[j+1];
			end
		end

		for (j = 1; j <= F; j++) begin : g_div
			logic [DUR_W:0] shifted;
			logic [DUR_W:0] diff;
			logic           ge;

			// Shift in a zero bit and try the subtract
			assign shifted = {drem_s[j-1], 1'b0};
			assign diff    = shifted - {1'b0, ddur_s[j-1]};
			assign ge      = (shifted >= {1'b0, ddur_s[j-1]});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[j] <= 1'b0;
				end else if (d_rdy[j]) begin
					dv_s[j] <= dv_s[j-1];
				end
			end

			always_ff @(posedge clk) begin
				if (d_rdy[j] && dv_s[j-1]) begin
					drem_s[j] <= ge ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
					dq_s[j]   <= {dq_s[j-1][F-2:0], ge};
					ddur_s[j] <= ddur_s[j-1];
					dsat_s[j] <= dsat_s[j-1];
					dop_s[j]  <= dop_s[j-1];
				end
			end
		end
	endgenerate

	// Phase select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= dv_s[F];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && dv_s[F]) begin
			phase_s3 <= dsat_s[F] ? ONE : {1'b0, dq_s[F]};
			op_s3    <= dop_s[F];
		end
	end

	assign out_valid = v_s3;
	assign out_phase = phase_s3;
	assign out_op    = op_s3;

endmodule

`default_nettype wire

### rtl/mjt_blend.sv
// Minimum-jerk blend s^3 * (10 - 15s + 6s^2) over pipelined multiplier stages, then a clamp to [0, one].
`timescale 1ns / 1ps
`default_nettype none

module mjt_blend #(
	parameter int unsigned FRACTION_BITS = mjt_pkg::FRAC_BITS_DEFAULT
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    in_op,
	input  wire  [FRACTION_BITS:0] in_phase,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic                   out_op,
	output logic [FRACTION_BITS:0] out_blend
);
	localparam int unsigned F    = FRACTION_BITS;
	localparam int unsigned SQ_W = 2 * F + 2;
	localparam int unsigned PW   = F + 6;
	localparam int unsigned MW   = F + 5;
	localparam int unsigned BP_W = 2 * F + 6;
	localparam logic [F:0]    ONE   = (F+1)'(1) << F;
	localparam logic [PW-1:0] ONE_P = PW'(1) << F;

	logic            v_s1, v_s2, v_s3, v_s4;
	logic            rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic            op_s1, op_s2, op_s3, op_s4;
	logic [SQ_W-1:0] sq_s1;
	logic [F:0]      s_s1;
	logic [SQ_W-1:0] cube_s2;
	logic            ppos_s2, ppos_s3;
	logic [MW-1:0]   pmag_s2;
	logic [BP_W-1:0] prod_s3;
	logic [F:0]      b_s4;

	logic [F:0]      s2_c;
	logic [F:0]      s3_c;
	logic [PW-1:0]   p_c;
	logic [PW-1:0]   bq_c;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// s^2 (s never exceeds one, so the top bit of the product is zero)
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			sq_s1 <= SQ_W'(in_phase) * SQ_W'(in_phase);
			s_s1  <= in_phase;
			op_s1 <= in_op;
		end
	end

	// s^3 product and the quadratic factor 10 - 15s + 6s^2
	assign s2_c = sq_s1[2*F:F];
	assign p_c  = (PW'(10) * ONE_P) - (PW'(15) * PW'(s_s1)) + (PW'(6) * PW'(s2_c));

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			cube_s2 <= SQ_W'(s2_c) * SQ_W'(s_s1);
			ppos_s2 <= !p_c[PW-1] && (p_c != '0);
			pmag_s2 <= p_c[MW-1:0];
			op_s2   <= op_s1;
		end
	end

	// s^3 times the factor
	assign s3_c = cube_s2[2*F:F];

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			prod_s3 <= BP_W'(s3_c) * BP_W'(pmag_s2);
			ppos_s3 <= ppos_s2;
			op_s3   <= op_s2;
		end
	end

	// Scale back and clamp to [0, one]
	assign bq_c = prod_s3[BP_W-1:F];

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			if (!ppos_s3) begin
				b_s4 <= '0;
			end else if (bq_c > ONE_P) begin
				b_s4 <= ONE;
			end else begin
				b_s4 <= bq_c[F:0];
			end
			op_s4 <= op_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_op    = op_s4;
	assign out_blend = b_s4;

endmodule

`default_nettype wire

### rtl/mjt_interp.sv
// Interpolation between the configured positions, rounding, saturation and anatomical angle.
`timescale 1ns / 1ps
`default_nettype none

module mjt_interp #(
	parameter int unsigned FRACTION_BITS = mjt_pkg::FRAC_BITS_DEFAULT
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 in_op,
	input  wire  [FRACTION_BITS:0]              in_blend,
	input  wire  mjt_pkg::cfg_t                 cfg,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [mjt_pkg::POS_W-1:0]    out_reference,
	output logic signed [mjt_pkg::ANAT_W-1:0]   out_anatomical
);
	import mjt_pkg::*;

	localparam int unsigned F    = FRACTION_BITS;
	localparam int unsigned PR_W = POS_W + F + 1;
	localparam int unsigned SM_W = PR_W + 1;
	localparam logic [SM_W-1:0] HALF = SM_W'(1) << (F - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic op_s1, op_s2;
	logic neg_s1, neg_s2;
	logic [POS_W-1:0]          mag_s1;
	logic [F:0]                b_s1;
	logic [PR_W-1:0]           prod_s2;
	logic signed [POS_W+1:0]   raw_s3;
	logic signed [POS_W-1:0]   ref_s4;
	logic signed [ANAT_W-1:0]  anat_s4;

	logic signed [ANAT_W-1:0]  delta_c;
	logic [ANAT_W-1:0]         abs_c;
	logic [SM_W-1:0]           sum_c;
	logic [POS_W-1:0]          r_c;
	logic signed [POS_W+1:0]   step_c;
	logic signed [POS_W+1:0]   ext18;
	logic signed [POS_W+1:0]   flex18;
	logic signed [POS_W+1:0]   lim_hi_c;
	logic signed [POS_W+1:0]   lim_c;
	logic signed [ANAT_W-1:0]  ext17;

	assign ext18  = {{2{cfg.extended_position[POS_W-1]}}, cfg.extended_position};
	assign flex18 = {{2{cfg.flexed_position[POS_W-1]}}, cfg.flexed_position};
	assign ext17  = {cfg.extended_position[POS_W-1], cfg.extended_position};

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Sign and magnitude of the travel (magnitude fits 16 bits)
	assign delta_c = ext17 - {cfg.flexed_position[POS_W-1], cfg.flexed_position};
	assign abs_c   = delta_c[ANAT_W-1] ? ANAT_W'(-delta_c) : ANAT_W'(delta_c);

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			neg_s1 <= delta_c[ANAT_W-1];
			mag_s1 <= abs_c[POS_W-1:0];
			b_s1   <= in_blend;
			op_s1  <= in_op;
		end
	end

	// Travel times blend
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_s2 <= PR_W'(mag_s1) * PR_W'(b_s1);
			neg_s2  <= neg_s1;
			op_s2   <= op_s1;
		end
	end

	// Round half away from zero on the magnitude, then apply from the start position
	assign sum_c  = {1'b0, prod_s2} + HALF;
	assign r_c    = sum_c[F+POS_W-1:F];
	assign step_c = neg_s2 ? -$signed({2'b00, r_c}) : $signed({2'b00, r_c});

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			raw_s3 <= (op_s2 == OP_EXTENSION) ? (flex18 + step_c) : (ext18 - step_c);
		end
	end

	// Limit to extended first, then to flexed
	assign lim_hi_c = (raw_s3 > ext18) ? ext18 : raw_s3;
	assign lim_c    = (lim_hi_c < flex18) ? flex18 : lim_hi_c;

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			ref_s4  <= lim_c[POS_W-1:0];
			anat_s4 <= lim_c[ANAT_W-1:0] - ext17;
		end
	end

	assign out_valid      = v_s4;
	assign out_reference  = ref_s4;
	assign out_anatomical = anat_s4;

endmodule

`default_nettype wire

### rtl/min_jerk_trajectory_generator.sv
// Top level of the min-jerk trajectory generator: configuration registers and the pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock while the output is not stalled and returns one reference per
// item, in order. The phase divider is a restoring divider with one quotient bit per
// stage, followed by four blend stages and four of interpolation and saturation. Every
// stage has its own valid bit and ready, so empty stages fill while the output waits.
// Configuration writes take effect at once and are accepted in every cycle; write them
// only while no item is in flight. Positions are signed Q3.12 radians, times are
// microsecond ticks, elapsed time is the modulo 2^32 difference of now_time and
// start_time.
module min_jerk_trajectory_generator #(
	parameter int unsigned FRACTION_BITS = mjt_pkg::FRAC_BITS_DEFAULT
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                opcode,
	input  wire  [mjt_pkg::TIME_W-1:0]         start_time,
	input  wire  [mjt_pkg::TIME_W-1:0]         now_time,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [mjt_pkg::POS_W-1:0]   reference_position,
	output logic signed [mjt_pkg::ANAT_W-1:0]  anatomical_position,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [mjt_pkg::IDX_W-1:0]          cfg_index,
	input  wire  [mjt_pkg::DATA_W-1:0]         cfg_data
);
	import mjt_pkg::*;

	localparam int unsigned F = FRACTION_BITS;

	cfg_t cfg_q;

	logic       ph_valid, ph_ready, ph_op;
	logic [F:0] ph_phase;
	logic       bl_valid, bl_ready, bl_op;
	logic [F:0] bl_blend;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extended_position  <= '0;
			cfg_q.flexed_position    <= '0;
			cfg_q.flexion_duration   <= DUR_RESET;
			cfg_q.extension_duration <= DUR_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_EXTENDED: begin
					cfg_q.extended_position <= cfg_data[POS_W-1:0];
				end
				REG_FLEXED: begin
					cfg_q.flexed_position <= cfg_data[POS_W-1:0];
				end
				REG_FLEX_DUR: begin
					cfg_q.flexion_duration <= cfg_data[DUR_W-1:0];
				end
				REG_EXT_DUR: begin
					cfg_q.extension_duration <= cfg_data[DUR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Phase: elapsed / duration, clamped to one
	mjt_phase #(
		.FRACTION_BITS(F)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.start_time(start_time),
		.now_time  (now_time),
		.cfg       (cfg_q),
		.out_valid (ph_valid),
		.out_ready (ph_ready),
		.out_op    (ph_op),
		.out_phase (ph_phase)
	);

	// Minimum-jerk blend
	mjt_blend #(
		.FRACTION_BITS(F)
	) u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ph_valid),
		.in_ready (ph_ready),
		.in_op    (ph_op),
		.in_phase (ph_phase),
		.out_valid(bl_valid),
		.out_ready(bl_ready),
		.out_op   (bl_op),
		.out_blend(bl_blend)
	);

	// Position interpolation and saturation
	mjt_interp #(
		.FRACTION_BITS(F)
	) u_interp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (bl_valid),
		.in_ready      (bl_ready),
		.in_op         (bl_op),
		.in_blend      (bl_blend),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_reference (reference_position),
		.out_anatomical(anatomical_position)
	);

endmodule

`default_nettype wire

### rtl/mjt_checker.sv
// Port-level checks of the min-jerk trajectory generator and their bind.
`timescale 1ns / 1ps
`default_nettype none

module mjt_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire signed [mjt_pkg::POS_W-1:0]    reference_position,
	input wire signed [mjt_pkg::ANAT_W-1:0]   anatomical_position
);
	// Items accepted but not yet delivered
	logic [7:0] inflight_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 8'd1;
		end else if (out_acc && !in_acc) begin
			inflight_q <= inflight_q - 8'd1;
		end
	end

	// No result without an item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 8'd0))
		else $error("result shown with no item in flight");

	// An empty pipeline must take an item
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == 8'd0) |-> in_ready)
		else $error("empty pipeline not ready");

	// A stalled result stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			($stable(reference_position) && $stable(anatomical_position)))
		else $error("result changed while stalled");

endmodule

bind min_jerk_trajectory_generator mjt_checker u_mjt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_ready           (in_ready),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.reference_position (reference_position),
	.anatomical_position(anatomical_position)
);

`default_nettype wire
